### hdl/c5s_pkg.sv
// shared types, constants and codes of the 5x5 convolution / sigmoid stream unit
package c5s_pkg;

   // default geometry
   localparam int KERNEL_SIZE_DEF = 5;
   localparam int MAX_WIDTH_DEF   = 64;
   localparam int HEIGHT_CAP      = 64;

   // field widths
   localparam int PIX_W      = 8;
   localparam int WT_W       = 16;
   localparam int WIDX_W     = 5;
   localparam int BIAS_W     = 16;
   localparam int DIM_W      = 7;
   localparam int OUT_POS_W  = 6;
   localparam int WI_W       = 24;
   localparam int ACT_W      = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USED_W = 2 * OUT_POS_W + WI_W + ACT_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd28;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd28;

   // request kinds
   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_PIXEL  = 1'b1;

   // arithmetic
   localparam int WI_MAX    = 8388607;
   localparam int WI_MIN    = -8388608;
   localparam int PIX_ONE   = 255;
   localparam int RND_HALF  = 127;
   localparam int FRAC_W    = 12;
   localparam int TERM_W    = 33;
   localparam int SACC_W    = 35;
   localparam int N_W       = 5;
   localparam int TERMS     = 16;
   localparam int POW_LIMIT = 24;
   localparam int POW_CNT_W = 5;
   localparam int DIV_NUM_W = 50;
   localparam int DIV_DEN_W = 34;

   // divider operand select
   localparam logic [1:0] DSEL_QUOT   = 2'd0;
   localparam logic [1:0] DSEL_SERIES = 2'd1;
   localparam logic [1:0] DSEL_FINAL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic           wt_load;
      logic           pix_load;
      logic           shift;
      logic           mac_clr;
      logic           mac_en;
      logic           div_start;
      logic [1:0]     div_sel;
      logic           sat_en;
      logic           ser_init;
      logic           pass;
      logic           ser_mul;
      logic           ser_upd;
      logic [N_W-1:0] n;
      logic           base_save;
      logic           e_save;
      logic           pow_en;
      logic           act_save;
      logic           out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
      logic mac_last;
      logic div_done;
      logic pow_done;
      logic out_free;
   } sts_type;

endpackage

### hdl/c5s_ram.sv
// generic single-write, single-read RAM with registered read data
module c5s_ram #(
   parameter int WIDTH = c5s_pkg::PIX_W,
   parameter int DEPTH = c5s_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hdl/c5s_div.sv
// restoring divider, one quotient bit per cycle
module c5s_div #(
   parameter int NUM_W = c5s_pkg::DIV_NUM_W,
   parameter int DEN_W = c5s_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // trial subtraction
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out as the quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

### hdl/c5s_dp.sv
// datapath: line buffers, window, kernel, multiply-accumulate, sigmoid arithmetic
module c5s_dp #(
   parameter int KERNEL_SIZE = c5s_pkg::KERNEL_SIZE_DEF,
   parameter int MAX_WIDTH   = c5s_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  c5s_pkg::cmd_type                  cmd,
   output c5s_pkg::sts_type                  sts,
   input  logic [c5s_pkg::WIDX_W-1:0]        weight_index,
   input  logic [c5s_pkg::WT_W-1:0]          weight_value,
   input  logic [c5s_pkg::PIX_W-1:0]         pixel,
   input  logic                              csr_we,
   input  logic [c5s_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c5s_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [c5s_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import c5s_pkg::*;

   localparam int TAP_N   = KERNEL_SIZE * KERNEL_SIZE;
   localparam int TAP_W   = $clog2(TAP_N);
   localparam int LROWS   = KERNEL_SIZE - 1;
   localparam int SLOT_W  = (LROWS > 1) ? $clog2(LROWS) : 1;
   localparam int SLOT_W1 = SLOT_W + 1;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CMP_W   = ((COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W) + 1;
   localparam int PROD_W  = PIX_W + 1 + WT_W;
   localparam int ACC_W   = PROD_W + $clog2(TAP_N);
   localparam int QB_W    = ACC_W + 2;
   localparam int SPROD_W = TERM_W + FRAC_W + 1;
   localparam int K_W     = WI_W - FRAC_W;
   localparam int PAD_W   = RSP_DATA_W - RSP_USED_W;
   localparam logic signed [QB_W-1:0] QB_MAX = QB_W'(WI_MAX);
   localparam logic signed [QB_W-1:0] QB_MIN = QB_W'(WI_MIN);
   localparam logic [TERM_W-1:0] ONE_Q32  = TERM_W'(1) << 32;
   localparam logic [FRAC_W:0]   FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;

   // configuration registers
   logic signed [BIAS_W-1:0] bias_ff;
   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= '0;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIAS:   bias_ff   <= csr_wdata[BIAS_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // kernel taps, out-of-range tap numbers are dropped
   logic signed [WT_W-1:0] taps_ff [TAP_N];

   always_ff @(posedge clock) begin
      if (cmd.wt_load && (int'(weight_index) < TAP_N)) begin
         taps_ff[TAP_W'(weight_index)] <= weight_value;
      end
   end

   // incoming pixel
   logic [PIX_W-1:0] pix_ff;

   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         pix_ff <= pixel;
      end
   end

   // frame position and clamped dimensions
   logic [COL_W-1:0]     col_ff;
   logic [OUT_POS_W-1:0] row_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [CMP_W-1:0]     w_cl;
   logic [CMP_W-1:0]     h_cl;
   logic [CMP_W-1:0]     c1;
   logic [CMP_W-1:0]     r1;
   logic                 end_row;
   logic                 end_frame;

   always_comb begin
      w_cl = CMP_W'(width_ff);
      if (w_cl < CMP_W'(KERNEL_SIZE)) begin
         w_cl = CMP_W'(KERNEL_SIZE);
      end else if (w_cl > CMP_W'(MAX_WIDTH)) begin
         w_cl = CMP_W'(MAX_WIDTH);
      end
      h_cl = CMP_W'(height_ff);
      if (h_cl < CMP_W'(KERNEL_SIZE)) begin
         h_cl = CMP_W'(KERNEL_SIZE);
      end else if (h_cl > CMP_W'(HEIGHT_CAP)) begin
         h_cl = CMP_W'(HEIGHT_CAP);
      end
   end

   assign c1        = CMP_W'(col_ff) + 1'b1;
   assign r1        = CMP_W'(row_ff) + 1'b1;
   assign end_row   = (c1 >= w_cl);
   assign end_frame = end_row && (r1 >= h_cl);
   assign sts.emit  = (c1 >= CMP_W'(KERNEL_SIZE)) && (r1 >= CMP_W'(KERNEL_SIZE));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (cmd.shift) begin
         if (end_row) begin
            col_ff <= '0;
            if (end_frame) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= row_ff + 1'b1;
               slot_ff <= (slot_ff == SLOT_W'(LROWS - 1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // result position held for the output stage
   logic [OUT_POS_W-1:0] pos_col_ff;
   logic [OUT_POS_W-1:0] pos_row_ff;
   logic                 pos_last_ff;
   logic [CMP_W-1:0]     col_left;
   logic [CMP_W-1:0]     row_top;

   assign col_left = CMP_W'(col_ff) - CMP_W'(KERNEL_SIZE - 1);
   assign row_top  = CMP_W'(row_ff) - CMP_W'(KERNEL_SIZE - 1);

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         pos_col_ff  <= col_left[OUT_POS_W-1:0];
         pos_row_ff  <= row_top[OUT_POS_W-1:0];
         pos_last_ff <= end_frame;
      end
   end

   // one line memory per buffered row, all read at the current column
   logic [PIX_W-1:0] line_rd [LROWS];

   for (genvar j = 0; j < LROWS; j++) begin : g_line
      c5s_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock (clock),
         .we    (cmd.shift && (slot_ff == SLOT_W'(j))),
         .waddr (col_ff),
         .wdata (pix_ff),
         .raddr (col_ff),
         .rdata (line_rd[j])
      );
   end

   // window shifts left, new column from line memories and the pixel
   logic [PIX_W-1:0] win_ff [TAP_N];
   logic [PIX_W-1:0] win_in [TAP_N];

   always_comb begin
      logic [SLOT_W1-1:0] sidx;
      win_in = win_ff;
      sidx   = '0;
      if (cmd.shift) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int jj = 0; jj < KERNEL_SIZE - 1; jj++) begin
               win_in[i*KERNEL_SIZE+jj] = win_ff[i*KERNEL_SIZE+jj+1];
            end
            if (i < KERNEL_SIZE - 1) begin
               sidx = {1'b0, slot_ff} + SLOT_W1'(i);
               if (sidx >= SLOT_W1'(LROWS)) begin
                  sidx = sidx - SLOT_W1'(LROWS);
               end
               win_in[i*KERNEL_SIZE+KERNEL_SIZE-1] = line_rd[sidx[SLOT_W-1:0]];
            end else begin
               win_in[i*KERNEL_SIZE+KERNEL_SIZE-1] = pix_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAP_N; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // multiply-accumulate, one tap per cycle
   logic [TAP_W-1:0]         mac_idx_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod;

   assign prod         = $signed({1'b0, win_ff[mac_idx_ff]}) * taps_ff[mac_idx_ff];
   assign sts.mac_last = (mac_idx_ff == TAP_W'(TAP_N - 1));

   always_ff @(posedge clock) begin
      if (cmd.mac_clr) begin
         mac_idx_ff <= '0;
         acc_ff     <= '0;
      end else if (cmd.mac_en) begin
         mac_idx_ff <= mac_idx_ff + 1'b1;
         acc_ff     <= acc_ff + ACC_W'(prod);
      end
   end

   // shared divider and its operands
   logic                 acc_neg;
   logic [ACC_W-1:0]     acc_mag;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] quot;
   logic                 div_done;
   logic [SPROD_W-1:0]   sprod_ff;
   logic [TERM_W-1:0]    e_ff;
   logic signed [WI_W-1:0] q_ff;
   logic [DIV_DEN_W-1:0] dd;
   logic                 q_neg;

   assign acc_neg = acc_ff[ACC_W-1];
   assign acc_mag = acc_neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign q_neg   = q_ff[WI_W-1];
   assign dd      = (DIV_DEN_W'(1) << 32) + DIV_DEN_W'(e_ff);

   always_comb begin
      case (cmd.div_sel)
         DSEL_SERIES: begin
            div_num = DIV_NUM_W'(sprod_ff);
            div_den = DIV_DEN_W'({cmd.n, {FRAC_W{1'b0}}});
         end
         DSEL_FINAL: begin
            div_num = (q_neg ? (DIV_NUM_W'(e_ff) << 16) : (DIV_NUM_W'(1) << 48))
                      + DIV_NUM_W'(dd >> 1);
            div_den = dd;
         end
         default: begin
            div_num = '0;
            div_den = DIV_DEN_W'(1);
         end
      endcase
   end

   c5s_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start && (cmd.div_sel != DSEL_QUOT)),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // rounded magnitude by 255: fold the bits above the low byte back onto it,
   // since 256 leaves remainder one, then one last compare and subtract
   logic             q255_start;
   logic             q255_run_ff;
   logic             q255_done_ff;
   logic [ACC_W-1:0] q255_rem_ff;
   logic [ACC_W-1:0] q255_quot_ff;
   logic [ACC_W-1:0] q255_hi;
   logic [ACC_W-1:0] q255_lo;

   assign q255_start = cmd.div_start && (cmd.div_sel == DSEL_QUOT);
   assign q255_hi    = q255_rem_ff >> PIX_W;
   assign q255_lo    = q255_rem_ff & ACC_W'({PIX_W{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) begin
         q255_run_ff  <= 1'b0;
         q255_done_ff <= 1'b0;
      end else begin
         q255_done_ff <= 1'b0;
         if (q255_start) begin
            q255_run_ff <= 1'b1;
         end else if (q255_run_ff && (q255_hi == '0)) begin
            q255_run_ff  <= 1'b0;
            q255_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q255_start) begin
         q255_rem_ff  <= acc_mag + ACC_W'(RND_HALF);
         q255_quot_ff <= '0;
      end else if (q255_run_ff) begin
         if (q255_hi != '0) begin
            q255_quot_ff <= q255_quot_ff + q255_hi;
            q255_rem_ff  <= q255_hi + q255_lo;
         end else if (q255_rem_ff >= ACC_W'(PIX_ONE)) begin
            q255_quot_ff <= q255_quot_ff + 1'b1;
            q255_rem_ff  <= q255_rem_ff - ACC_W'(PIX_ONE);
         end
      end
   end

   assign sts.div_done = div_done || q255_done_ff;

   // rounded quotient by 255, signed, plus bias, saturated
   logic signed [QB_W-1:0] qs;
   logic signed [QB_W-1:0] qb;

   assign qs = acc_neg ? -$signed(QB_W'(q255_quot_ff)) : $signed(QB_W'(q255_quot_ff));
   assign qb = qs + QB_W'(bias_ff);

   always_ff @(posedge clock) begin
      if (cmd.sat_en) begin
         if (qb > QB_MAX) begin
            q_ff <= WI_W'(WI_MAX);
         end else if (qb < QB_MIN) begin
            q_ff <= WI_W'(WI_MIN);
         end else begin
            q_ff <= qb[WI_W-1:0];
         end
      end
   end

   // magnitude split into integer and fraction
   logic [WI_W-1:0]   tmag;
   logic [K_W-1:0]    kint;
   logic              k_big;
   logic [FRAC_W:0]   f_sel;

   assign tmag  = q_neg ? WI_W'(-q_ff) : WI_W'(q_ff);
   assign kint  = tmag[WI_W-1:FRAC_W];
   assign k_big = (kint >= K_W'(POW_LIMIT));
   assign f_sel = cmd.pass ? {1'b0, tmag[FRAC_W-1:0]} : FRAC_ONE;

   // Taylor series of e^-x, one term per divider pass
   logic [TERM_W-1:0]        term_ff;
   logic signed [SACC_W-1:0] sacc_ff;
   logic [TERM_W-1:0]        sacc_pos;
   logic [TERM_W-1:0]        base_ff;
   logic [TERM_W-1:0]        qterm;

   assign qterm    = quot[TERM_W-1:0];
   assign sacc_pos = sacc_ff[SACC_W-1] ? '0 : sacc_ff[TERM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.ser_init) begin
         term_ff <= ONE_Q32;
         sacc_ff <= SACC_W'(ONE_Q32);
      end else if (cmd.ser_upd) begin
         term_ff <= qterm;
         if (cmd.n[0]) begin
            sacc_ff <= sacc_ff - $signed(SACC_W'(qterm));
         end else begin
            sacc_ff <= sacc_ff + $signed(SACC_W'(qterm));
         end
      end
      if (cmd.ser_mul) begin
         sprod_ff <= SPROD_W'(term_ff * f_sel);
      end
      if (cmd.base_save) begin
         base_ff <= sacc_pos;
      end
   end

   // integer part: repeated product with e^-1
   logic [POW_CNT_W-1:0]  pow_cnt_ff;
   logic [2*TERM_W-1:0]   pmul;

   assign pmul         = e_ff * base_ff;
   assign sts.pow_done = k_big || (K_W'(pow_cnt_ff) == kint);

   always_ff @(posedge clock) begin
      if (cmd.e_save) begin
         e_ff       <= k_big ? '0 : sacc_pos;
         pow_cnt_ff <= '0;
      end else if (cmd.pow_en) begin
         e_ff       <= pmul[32+TERM_W-1:32];
         pow_cnt_ff <= pow_cnt_ff + 1'b1;
      end
   end

   // activation, capped
   logic [ACT_W-1:0] act_ff;

   always_ff @(posedge clock) begin
      if (cmd.act_save) begin
         act_ff <= (quot > DIV_NUM_W'({ACT_W{1'b1}})) ? {ACT_W{1'b1}} : quot[ACT_W-1:0];
      end
   end

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, act_ff, q_ff, pos_row_ff, pos_col_ff};
         rsp_last_ff <= pos_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

### hdl/c5s_ctrl.sv
// controller: sequences window update, accumulation, division and sigmoid steps
module c5s_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tuser,
   output logic             req_tready,
   output c5s_pkg::cmd_type cmd,
   input  c5s_pkg::sts_type sts
);
   import c5s_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SHIFT = 4'd1;
   localparam logic [3:0] ST_MAC   = 4'd2;
   localparam logic [3:0] ST_QDIV  = 4'd3;
   localparam logic [3:0] ST_QWAIT = 4'd4;
   localparam logic [3:0] ST_SINIT = 4'd5;
   localparam logic [3:0] ST_SMUL  = 4'd6;
   localparam logic [3:0] ST_SDIV  = 4'd7;
   localparam logic [3:0] ST_SWAIT = 4'd8;
   localparam logic [3:0] ST_SEND  = 4'd9;
   localparam logic [3:0] ST_POW   = 4'd10;
   localparam logic [3:0] ST_FDIV  = 4'd11;
   localparam logic [3:0] ST_FWAIT = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   logic [3:0]     state_ff, state_in;
   logic [N_W-1:0] n_ff, n_in;
   logic           pass_ff, pass_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      pass_in    = pass_ff;
      cmd        = '0;
      cmd.n      = n_ff;
      cmd.pass   = pass_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_PIXEL) begin
                  cmd.pix_load = 1'b1;
                  state_in     = ST_SHIFT;
               end else begin
                  cmd.wt_load = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift   = 1'b1;
            cmd.mac_clr = 1'b1;
            state_in    = sts.emit ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (sts.mac_last) begin
               state_in = ST_QDIV;
            end
         end
         ST_QDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_QUOT;
            state_in      = ST_QWAIT;
         end
         ST_QWAIT: begin
            if (sts.div_done) begin
               cmd.sat_en = 1'b1;
               pass_in    = 1'b0;
               state_in   = ST_SINIT;
            end
         end
         ST_SINIT: begin
            cmd.ser_init = 1'b1;
            n_in         = N_W'(1);
            state_in     = ST_SMUL;
         end
         ST_SMUL: begin
            cmd.ser_mul = 1'b1;
            state_in    = ST_SDIV;
         end
         ST_SDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_SERIES;
            state_in      = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (sts.div_done) begin
               cmd.ser_upd = 1'b1;
               if (n_ff == N_W'(TERMS)) begin
                  state_in = ST_SEND;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = ST_SMUL;
               end
            end
         end
         ST_SEND: begin
            if (!pass_ff) begin
               cmd.base_save = 1'b1;
               pass_in       = 1'b1;
               state_in      = ST_SINIT;
            end else begin
               cmd.e_save = 1'b1;
               state_in   = ST_POW;
            end
         end
         ST_POW: begin
            if (sts.pow_done) begin
               state_in = ST_FDIV;
            end else begin
               cmd.pow_en = 1'b1;
            end
         end
         ST_FDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_FINAL;
            state_in      = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (sts.div_done) begin
               cmd.act_save = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         pass_ff  <= pass_in;
      end
   end

   // a pixel request always goes to the window update next
   a_pix_to_shift: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_PIXEL) |=> (state_ff == ST_SHIFT))
      else $error("pixel request did not start window update");

   // divider results arrive only while a wait state expects them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_QWAIT || state_ff == ST_SWAIT || state_ff == ST_FWAIT))
      else $error("divider finished outside a wait state");

   // series ends only after the last term
   a_series_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (n_ff == N_W'(TERMS)))
      else $error("series ended early");

   // datapath steps never overlap
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.shift, cmd.mac_en, cmd.div_start, cmd.ser_mul, cmd.ser_upd,
                cmd.pow_en, cmd.out_load}))
      else $error("overlapping datapath commands");
endmodule

### hdl/conv5x5_sigmoid_stream_unit.sv
// top level of the streaming 5x5 valid convolution with bias and sigmoid
//
//   port group  dir   contents
//   req_*       in    tuser: opcode; tdata: weight_index, weight_value, pixel
//   rsp_*       out   tdata: out_col, out_row, weighted_input, activation; tlast: last
//   csr_*       in    register writes: 0 bias, 1 image_width, 2 image_height
//
// a weight load is taken straight from idle; a pixel that closes no window is loaded, then
// shifts into the window; a pixel that closes a window then runs the tap-by-tap MAC, the
// divide by 255, two 16-term series on the 50-step shared divider, one product per unit
// of the integer part of |weighted_input| (at most 23) and the last divide
// reset is synchronous; it clears counters, window, registers and the output stage
// a result waits in the output register while the next request is accepted; the next
// window result stalls the block, and with it the input, until that register is taken
module conv5x5_sigmoid_stream_unit #(
   parameter int KERNEL_SIZE = c5s_pkg::KERNEL_SIZE_DEF,
   parameter int MAX_WIDTH   = c5s_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] weight_index, [20:5] weight_value, [28:21] pixel
   input  logic [c5s_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                           req_tuser,
   input  logic                           csr_we,
   input  logic [c5s_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [c5s_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [5:0] out_col, [11:6] out_row, [35:12] weighted_input, [51:36] activation
   output logic [c5s_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import c5s_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   c5s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // arithmetic and storage
   c5s_dp #(
      .KERNEL_SIZE (KERNEL_SIZE),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .weight_index (req_tdata[WIDX_W-1:0]),
      .weight_value (req_tdata[WIDX_W+WT_W-1:WIDX_W]),
      .pixel        (req_tdata[WIDX_W+WT_W+PIX_W-1:WIDX_W+WT_W]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );
endmodule

### bench/conv5x5_sigmoid_checker.sv
`timescale 1ns / 100ps
// predictor and result checker of the 5x5 convolution / sigmoid stream unit
module conv5x5_sigmoid_checker
   import c5s_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic                    req_tuser,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    rsp_tlast,
   output int                      fail_count,
   output int                      pending
);

   localparam int KS    = KERNEL_SIZE_DEF;
   localparam int NTAPS = KS * KS;
   localparam int LROWS = KS - 1;

   typedef struct {
      bit [OUT_POS_W-1:0] col;
      bit [OUT_POS_W-1:0] row;
      bit [WI_W-1:0]      wi;
      bit [ACT_W-1:0]     act;
      bit                 last;
   } window_result_type;

   window_result_type window_results[$];

   int          kernel_w[NTAPS];
   bit [7:0]    line_mem[LROWS*MAX_WIDTH_DEF];
   bit [7:0]    win[NTAPS];
   int unsigned col_cnt, row_cnt;
   int          bias_q;
   int unsigned width_q, height_q;

   // e^-(f/4096) in Q0.32 by truncated alternating series
   function automatic longint unsigned exp_series(int unsigned f);
      longint unsigned term;
      longint          acc;
      term = 64'd1 << 32;
      acc  = longint'(64'd1 << 32);
      for (int n = 1; n <= TERMS; n++) begin
         term = (term * f) / (64'd4096 * n);
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   // e^-(t/4096) in Q0.32
   function automatic longint unsigned exp_q32(int unsigned t);
      int unsigned     k;
      longint unsigned p;
      longint unsigned base;
      k = t >> FRAC_W;
      if (k >= POW_LIMIT) return 64'd0;
      p    = exp_series(t & 4095);
      base = exp_series(4096);
      for (int i = 0; i < k; i++) p = (p * base) >> 32;
      return p;
   endfunction

   function automatic bit [ACT_W-1:0] sigmoid_q16(int z);
      longint unsigned e, d, a;
      if (z >= 0) begin
         e = exp_q32(z);
         d = (64'd1 << 32) + e;
         a = ((64'd1 << 48) + d / 2) / d;
         if (a > 65535) a = 65535;
      end else begin
         e = exp_q32(-z);
         d = (64'd1 << 32) + e;
         a = ((e << 16) + d / 2) / d;
      end
      return a[ACT_W-1:0];
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // one accepted request: update state, maybe queue a window result
   task automatic predict_request(bit op, bit [REQ_DATA_W-1:0] d);
      int unsigned       w, h, c, r;
      bit [7:0]          px;
      bit                end_row, end_frame;
      longint            sum, q;
      window_result_type res;
      w = clamp_dim(width_q, KS, MAX_WIDTH_DEF);
      h = clamp_dim(height_q, KS, HEIGHT_CAP);
      c = col_cnt;
      r = row_cnt;
      if (op == OP_WEIGHT) begin
         if (d[4:0] < NTAPS) kernel_w[d[4:0]] = int'($signed(d[20:5]));
         return;
      end
      px = d[28:21];
      if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
      // shift window and take the new column
      for (int i = 0; i < KS; i++) begin
         for (int j = 0; j < KS - 1; j++) win[i*KS+j] = win[i*KS+j+1];
         if (i < KS - 1) win[i*KS+KS-1] = line_mem[((r + i) % LROWS) * MAX_WIDTH_DEF + c];
         else win[i*KS+KS-1] = px;
      end
      line_mem[(r % LROWS) * MAX_WIDTH_DEF + c] = px;
      end_row   = (c + 1 >= w);
      end_frame = end_row && (r + 1 >= h);
      if (end_row) begin
         col_cnt = 0;
         row_cnt = end_frame ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
      if (!((c + 1 >= KS) && (r + 1 >= KS))) return;
      sum = 0;
      for (int i = 0; i < NTAPS; i++) sum += longint'(win[i]) * kernel_w[i];
      q = (sum >= 0) ? (sum + RND_HALF) / PIX_ONE : -((-sum + RND_HALF) / PIX_ONE);
      q += bias_q;
      if (q > WI_MAX) q = WI_MAX;
      if (q < WI_MIN) q = WI_MIN;
      res.col  = OUT_POS_W'(c - (KS - 1));
      res.row  = OUT_POS_W'(r - (KS - 1));
      res.wi   = WI_W'(q);
      res.act  = sigmoid_q16(int'(q));
      res.last = end_frame;
      window_results.insert(window_results.size(), res);
   endtask

   // watch all three ports at each edge
   always @(posedge clock) begin
      window_result_type exp_r;
      bit                bad;
      if (reset) begin
         window_results.delete();
         foreach (kernel_w[i]) kernel_w[i] = 0;
         foreach (line_mem[i]) line_mem[i] = 0;
         foreach (win[i]) win[i] = 0;
         col_cnt    = 0;
         row_cnt    = 0;
         bias_q     = 0;
         width_q    = RST_WIDTH;
         height_q   = RST_HEIGHT;
         fail_count = 0;
      end else begin
         // results first; a request can not produce one in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (window_results.size() == 0) begin
               if (fail_count < 10)
                  $display("[%0t] unexpected result: tdata=%h last=%b", $realtime,
                           rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               exp_r = window_results.pop_front();
               bad = (rsp_tdata[5:0] != exp_r.col) || (rsp_tdata[11:6] != exp_r.row) ||
                     (rsp_tdata[35:12] != exp_r.wi) || (rsp_tdata[51:36] != exp_r.act) ||
                     (rsp_tlast != exp_r.last);
               if (bad) begin
                  if (fail_count < 10)
                     $display({"[%0t] mismatch: expected col=%0d row=%0d wi=%h act=%h last=%b",
                               " / got col=%0d row=%0d wi=%h act=%h last=%b"}, $realtime,
                              exp_r.col, exp_r.row, exp_r.wi, exp_r.act, exp_r.last,
                              rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[35:12],
                              rsp_tdata[51:36], rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BIAS:   bias_q   = int'($signed(csr_wdata[BIAS_W-1:0]));
               CSR_WIDTH:  width_q  = csr_wdata[DIM_W-1:0];
               CSR_HEIGHT: height_q = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
      end
      pending = window_results.size();
   end

endmodule

### bench/tb_conv5x5_sigmoid_stream_unit.sv
`timescale 1ns / 100ps
// stimulus and verdict for the 5x5 convolution / sigmoid stream unit
module tb_conv5x5_sigmoid_stream_unit;
   import c5s_pkg::*;

   localparam int CYCLE_LIMIT  = 6000000;
   localparam int HOLD_CYCLES  = 6000;
   localparam int RANDOM_ITEMS = 280;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   int                    fail_count;
   int                    pending;

   bit steady;
   bit long_hold;
   int hold_count;
   int cycle_count;
   int random_sent;

   conv5x5_sigmoid_stream_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   conv5x5_sigmoid_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
      end else if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 28);
      end
   end

   // offer one request and wait for its acceptance
   task automatic send_request(bit op, bit [REQ_DATA_W-1:0] d);
      req_tdata  <= d;
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_weight(int idx, int val);
      send_request(OP_WEIGHT, {3'($urandom), 8'($urandom), 16'(val), 5'(idx)});
   endtask

   task automatic send_pixel(int px);
      send_request(OP_PIXEL, {3'b0, 8'(px), 16'($urandom), 5'($urandom)});
   endtask

   task automatic write_reg(bit [CSR_IDX_W-1:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // let every expected result arrive, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // kernel load: narrow weights keep the sigmoid off its rails
   task automatic load_kernel(bit narrow);
      for (int i = 0; i < 25; i++)
         send_weight(i, narrow ? $signed($urandom_range(1200)) - 600 : int'($urandom));
   endtask

   function automatic int pick_pixel();
      int sel;
      sel = $urandom_range(9);
      return (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(255);
   endfunction

   // pixels of a frame with the odd weight update mixed in
   task automatic send_pixels(int npix, bit count_random);
      for (int i = 0; i < npix; i++) begin
         if ($urandom_range(99) < 5) begin
            send_weight($urandom_range(31), $signed($urandom_range(1200)) - 600);
            if (count_random) random_sent++;
         end
         send_pixel(pick_pixel());
         if (count_random) random_sent++;
      end
   endtask

   initial begin
      int w, h, sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_WEIGHT;
      csr_we     = 1'b0;
      csr_index  = CSR_BIAS;
      csr_wdata  = '0;
      steady     = 1'b0;
      long_hold  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame, extreme bias and extreme taps
      write_reg(CSR_WIDTH, 5);
      write_reg(CSR_HEIGHT, 5);
      write_reg(CSR_BIAS, 32767);
      load_kernel(1'b1);
      send_weight(0, 32767);
      send_weight(24, -32768);
      send_weight(31, 16'h1234);   // tap index out of range is ignored
      send_weight(25, -1);
      for (int i = 0; i < 25; i++) send_pixel(255);
      drain();
      write_reg(CSR_BIAS, -32768);
      for (int i = 0; i < 25; i++) send_pixel(0);
      drain();

      // shrink the frame mid-way: counters past the new end wrap
      write_reg(CSR_BIAS, 0);
      write_reg(CSR_WIDTH, 8);
      write_reg(CSR_HEIGHT, 8);
      send_pixels(46, 1'b0);
      drain();
      write_reg(CSR_WIDTH, 5);
      write_reg(CSR_HEIGHT, 5);
      send_pixel(200);
      drain();

      // widest row (clamped), tallest frame, clamped-up dimensions
      write_reg(CSR_WIDTH, 127);
      send_pixels(320, 1'b0);
      drain();
      write_reg(CSR_WIDTH, 5);
      write_reg(CSR_HEIGHT, 64);
      send_pixels(320, 1'b0);
      drain();
      write_reg(CSR_WIDTH, 0);
      write_reg(CSR_HEIGHT, 0);
      send_pixels(25, 1'b0);
      drain();

      // random frames of small size; the held frame is large enough to fill the block
      random_sent = 0;
      for (int frame_no = 0; (random_sent < RANDOM_ITEMS) || (frame_no < 4); frame_no++) begin
         w = (frame_no == 1) ? 8 : $urandom_range(5, 8);
         h = (frame_no == 1) ? 7 : $urandom_range(5, 7);
         write_reg(CSR_WIDTH, w);
         write_reg(CSR_HEIGHT, h);
         sel = $urandom_range(9);
         write_reg(CSR_BIAS, (sel == 0) ? -32768 : (sel == 1) ? 32767 :
                             $signed($urandom_range(16384)) - 8192);
         if ($urandom_range(99) < 30) begin
            load_kernel($urandom_range(3) != 0);
            random_sent += 25;
         end
         steady    = (frame_no == 3);
         long_hold = (frame_no == 1);
         send_pixels(w * h, 1'b1);
         drain();
         long_hold = 1'b0;
      end
      steady = 1'b0;

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
